>>> rtl/core/emnl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the efficiency map nearest lookup.
// No dependencies.
package emnl_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;

	localparam int SPD_W   = 16;
	localparam int TRQ_W   = 16;
	localparam int EFF_W   = 15;
	localparam int DIST_W  = 17;
	localparam int IDX_W   = 6;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 7;

	localparam int SCAN_MAX = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
	localparam int SCAN_IW  = $clog2(SCAN_MAX);
	localparam int CNT_W    = $clog2(SCAN_MAX + 1);
	localparam int COL_IW   = $clog2(MAX_COLUMNS);
	localparam int ROW_IW   = $clog2(MAX_ROWS);
	localparam int GRID_N   = MAX_ROWS * MAX_COLUMNS;
	localparam int GRID_AW  = $clog2(GRID_N);
	localparam int GRID_W   = TRQ_W + EFF_W;

	localparam logic [1:0] REQ_LOAD_SPEED = 2'd0;
	localparam logic [1:0] REQ_LOAD_CELL  = 2'd1;
	localparam logic [1:0] REQ_QUERY      = 2'd2;

	localparam logic [CFG_IW-1:0] REG_SPEED_COLUMNS = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_TORQUE_ROWS   = CFG_IW'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPD,
		ST_TRQ,
		ST_DONE
	} emnl_state_t;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [IDX_W-1:0]        column_index;
		logic [IDX_W-1:0]        row_index;
		logic signed [SPD_W-1:0] speed_value;
		logic signed [TRQ_W-1:0] torque_value;
		logic [EFF_W-1:0]        efficiency_in;
	} emnl_req_t;

	typedef struct packed {
		logic [EFF_W-1:0] efficiency_out;
		logic [IDX_W-1:0] speed_hit;
		logic [IDX_W-1:0] torque_hit;
		logic             map_empty;
	} emnl_rsp_t;

	function automatic logic [DIST_W-1:0] abs_diff(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [DIST_W-1:0] diff;
		diff = DIST_W'(a) - DIST_W'(b);
		return diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
	endfunction

endpackage

>>> rtl/core/efficiency_map_nearest_lookup.sv
`timescale 1ns / 1ps
// Top level of the efficiency map nearest lookup: control, scan datapath, memories.
// Depends on emnl_pkg and emnl_ram.
// Load requests give no result; the next request is taken at once.
// A query holds the request side while it reads one entry per cycle from the speed memory,
// then from the grid memory; an empty map skips both scans.
// The result register frees the request side.
// Reset clears counts, control and the result valid flag; memories are not cleared.
module efficiency_map_nearest_lookup import emnl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  emnl_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output emnl_rsp_t         rsp
);

	emnl_state_t state_q, state_d;

	logic [CNT_W-1:0]   cols_q, rows_q, limit;
	logic [SCAN_IW-1:0] issue_q, idx_s1;
	logic               issue_on_q, issue_last, vld_s1, last_s1;
	logic               req_fire, is_query, map_is_empty, scan_start, rsp_load;
	logic               empty_q, better;

	logic signed [SPD_W-1:0] spd_q;
	logic signed [TRQ_W-1:0] trq_q;
	logic [DIST_W-1:0]       best_d_q, cand_d;
	logic [COL_IW-1:0]       best_c_q;
	logic [ROW_IW-1:0]       best_r_q;
	logic [EFF_W-1:0]        best_eff_q;
	logic [15:0]             operand, target;

	logic               spd_we, grid_we;
	logic [COL_IW-1:0]  spd_waddr, spd_raddr;
	logic [SPD_W-1:0]   spd_rdata;
	logic [GRID_AW-1:0] grid_waddr, grid_raddr;
	logic [GRID_W-1:0]  grid_rdata;

	logic      rsp_valid_q;
	emnl_rsp_t rsp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= '0;
			rows_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SPEED_COLUMNS) begin
				cols_q <= (int'(cfg_data) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS)
					: CNT_W'(cfg_data);
			end else if (cfg_index == REG_TORQUE_ROWS) begin
				rows_q <= (int'(cfg_data) > MAX_ROWS) ? CNT_W'(MAX_ROWS)
					: CNT_W'(cfg_data);
			end
		end
	end

	assign req_fire     = req_valid && req_ready;
	assign is_query     = (req.req_type == REQ_QUERY);
	assign map_is_empty = (cols_q == '0) || (rows_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		scan_start = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && is_query) begin
					if (map_is_empty) begin
						state_d = ST_DONE;
					end else begin
						state_d    = ST_SPD;
						scan_start = 1'b1;
					end
				end
			end
			ST_SPD: begin
				if (vld_s1 && last_s1) begin
					state_d    = ST_TRQ;
					scan_start = 1'b1;
				end
			end
			ST_TRQ: begin
				if (vld_s1 && last_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign limit      = (state_q == ST_TRQ) ? rows_q : cols_q;
	assign issue_last = ((CNT_W'(issue_q) + CNT_W'(1)) == limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			issue_on_q <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			last_s1    <= 1'b0;
		end else begin
			if (scan_start) begin
				issue_q    <= '0;
				issue_on_q <= 1'b1;
			end else if (issue_on_q) begin
				issue_q    <= issue_q + SCAN_IW'(1);
				issue_on_q <= !issue_last;
			end
			vld_s1  <= issue_on_q;
			idx_s1  <= issue_q;
			last_s1 <= issue_last;
		end
	end

	assign operand = (state_q == ST_SPD) ? spd_rdata : grid_rdata[EFF_W +: TRQ_W];
	assign target  = (state_q == ST_SPD) ? spd_q : trq_q;
	assign cand_d  = abs_diff(operand, target);
	assign better  = (idx_s1 == '0) || (cand_d < best_d_q);

	always_ff @(posedge clk) begin
		if (req_fire && is_query) begin
			spd_q   <= req.speed_value;
			trq_q   <= req.torque_value;
			empty_q <= map_is_empty;
		end
		if (vld_s1 && better) begin
			best_d_q <= cand_d;
			if (state_q == ST_SPD) begin
				best_c_q <= idx_s1[COL_IW-1:0];
			end else begin
				best_r_q   <= idx_s1[ROW_IW-1:0];
				best_eff_q <= grid_rdata[EFF_W-1:0];
			end
		end
	end

	assign spd_we     = req_fire && (req.req_type == REQ_LOAD_SPEED)
		&& (int'(req.column_index) < MAX_COLUMNS);
	assign grid_we    = req_fire && (req.req_type == REQ_LOAD_CELL)
		&& (int'(req.column_index) < MAX_COLUMNS) && (int'(req.row_index) < MAX_ROWS);
	assign spd_waddr  = COL_IW'(req.column_index);
	assign spd_raddr  = issue_q[COL_IW-1:0];
	assign grid_waddr = GRID_AW'(int'(req.row_index) * MAX_COLUMNS
		+ int'(req.column_index));
	assign grid_raddr = GRID_AW'(int'(issue_q[ROW_IW-1:0]) * MAX_COLUMNS + int'(best_c_q));

	emnl_ram #(
		.WIDTH(SPD_W),
		.DEPTH(MAX_COLUMNS)
	) u_spd_ram (
		.clk   (clk),
		.we    (spd_we),
		.waddr (spd_waddr),
		.wdata (req.speed_value),
		.raddr (spd_raddr),
		.rdata (spd_rdata)
	);

	emnl_ram #(
		.WIDTH(GRID_W),
		.DEPTH(GRID_N)
	) u_grid_ram (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata ({req.torque_value, req.efficiency_in}),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.map_empty      <= empty_q;
			rsp_q.efficiency_out <= empty_q ? '0 : best_eff_q;
			rsp_q.speed_hit      <= empty_q ? '0 : IDX_W'(best_c_q);
			rsp_q.torque_hit     <= empty_q ? '0 : IDX_W'(best_r_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/core/emnl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module emnl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/emnl_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the efficiency map nearest lookup, bound to the top level.
// Depends on emnl_pkg.
module emnl_chk import emnl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [CFG_IW-1:0] cfg_index,
	input logic [CFG_DW-1:0] cfg_data,
	input logic              req_valid,
	input logic              req_ready,
	input emnl_req_t         req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input emnl_rsp_t         rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.map_empty |-> rsp.efficiency_out == '0
			&& rsp.speed_hit == '0 && rsp.torque_hit == '0)
		else $error("empty-map result carries data");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_QUERY |=> !req_ready)
		else $error("request taken during query");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type != REQ_QUERY |=> !$rose(rsp_valid))
		else $error("load produced a result");

endmodule

bind efficiency_map_nearest_lookup emnl_chk u_emnl_chk (.*);
